// ----- src/slsr_pkg.sv -----
// Package: types, field layouts and codes for the serial link sequencer.
`timescale 1ns / 1ps
package slsr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] RETX_RESET = 16'd4094;
  localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] START_CLR_MASK = 8'h7F;
  localparam int unsigned CTRL_START_BIT = 7;
  localparam int unsigned CTRL_CLOCK_BIT = 0;

  localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_CYCLES = 2'd1;

  localparam logic [1:0] REQ_STEP = 2'd0;
  localparam logic [1:0] REQ_WR_DATA = 2'd1;
  localparam logic [1:0] REQ_WR_CTRL = 2'd2;

  localparam logic [1:0] SEND_IDLE = 2'd0;
  localparam logic [1:0] SEND_WAIT = 2'd1;
  localparam logic [1:0] SEND_ANSWERED = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] elapsed_cycles;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_seq;
    logic [BYTE_W-1:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_seq;
    logic [BYTE_W-1:0] tx_data;
    logic              resend_valid;
    logic [BYTE_W-1:0] resend_seq;
    logic [BYTE_W-1:0] resend_data;
    logic              rx_taken;
    logic              irq_request;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] control_reg;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_reg;
    logic [BYTE_W-1:0]  ctrl_reg;
    logic [BYTE_W-1:0]  last_seq;
    logic [BYTE_W-1:0]  last_byte;
    logic [BYTE_W-1:0]  exp_seq;
    logic [TIMER_W-1:0] timer;
    logic [1:0]         send_status;
  } link_state_t;

  typedef struct packed {
    logic               link_mode;
    logic [TIMER_W-1:0] retx_cycles;
  } link_cfg_t;

endpackage

// ----- src/serial_link_seq_retransmit_top.sv -----
// Top level: input register, link state, step logic and result register.
// Accepted items pass the input register, the step logic and the result register.
// Throughput: one item per cycle; the state update sits in the single step stage.
// A stalled result holds the step stage, which holds the input register.
// Reset (synchronous, rst_n low): link state and config return to reset values,
// both stages empty; the block accepts items in the first cycle after reset.
`timescale 1ns / 1ps
module serial_link_seq_retransmit_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  slsr_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output slsr_pkg::out_item_t                   out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [slsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slsr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic                  s1_valid_r;
  slsr_pkg::in_item_t    s1_item_r;
  logic                  out_valid_r;
  slsr_pkg::out_item_t   out_item_r;
  slsr_pkg::link_state_t st_r;
  slsr_pkg::link_state_t st_nxt;
  slsr_pkg::out_item_t   res;
  slsr_pkg::link_cfg_t   cfg_r;
  logic                  s2_ready;
  logic                  s2_load;
  logic                  in_take;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s2_load = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_take = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  slsr_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s2_ready || !s1_valid_r) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.data_reg <= '0;
      st_r.ctrl_reg <= '0;
      st_r.last_seq <= '0;
      st_r.last_byte <= '0;
      st_r.exp_seq <= 8'd1;
      st_r.timer <= '0;
      st_r.send_status <= slsr_pkg::SEND_IDLE;
    end else if (s2_load) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_mode <= 1'b0;
      cfg_r.retx_cycles <= slsr_pkg::RETX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slsr_pkg::CFG_LINK_MODE: cfg_r.link_mode <= cfg_data[0];
        slsr_pkg::CFG_RETX_CYCLES: cfg_r.retx_cycles <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_irq_clears_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.irq_request) |->
      !out_item_r.control_reg[slsr_pkg::CTRL_START_BIT])
    else $error("interrupt raised with start bit still set");

  a_send_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s2_load) |-> ((st_r.send_status == slsr_pkg::SEND_IDLE) ||
                        (st_r.send_status == slsr_pkg::SEND_WAIT) ||
                        (st_r.send_status == slsr_pkg::SEND_ANSWERED)))
    else $error("illegal send status");

endmodule

// ----- src/slsr_step.sv -----
// Step logic: next link state and result item for one request.
`timescale 1ns / 1ps
module slsr_step (
  input  slsr_pkg::link_state_t st,
  input  slsr_pkg::link_cfg_t   cfg,
  input  slsr_pkg::in_item_t    item,
  output slsr_pkg::link_state_t st_nxt,
  output slsr_pkg::out_item_t   res
);

  function automatic logic [slsr_pkg::TIMER_W-1:0] timer_add(
    input logic [slsr_pkg::TIMER_W-1:0] t,
    input logic [slsr_pkg::BYTE_W-1:0]  c
  );
    logic [slsr_pkg::TIMER_W:0] sum;
    sum = {1'b0, t} + {{(slsr_pkg::TIMER_W + 1 - slsr_pkg::BYTE_W){1'b0}}, c};
    return sum[slsr_pkg::TIMER_W] ? {slsr_pkg::TIMER_W{1'b1}} :
                                    sum[slsr_pkg::TIMER_W-1:0];
  endfunction

  always_comb begin
    slsr_pkg::link_state_t s;
    slsr_pkg::out_item_t   r;
    logic start;
    logic internal;
    logic seq_ok;
    s = st;
    r = '0;
    start = st.ctrl_reg[slsr_pkg::CTRL_START_BIT];
    internal = st.ctrl_reg[slsr_pkg::CTRL_CLOCK_BIT];
    seq_ok = item.rx_valid && (item.rx_seq == st.exp_seq);
    case (item.req_type)
      slsr_pkg::REQ_WR_DATA: begin
        s.data_reg = item.write_value;
      end
      slsr_pkg::REQ_WR_CTRL: begin
        s.ctrl_reg = item.write_value;
      end
      slsr_pkg::REQ_STEP: begin
        if (!cfg.link_mode) begin
          if (start && internal) begin
            s.data_reg = slsr_pkg::IDLE_BYTE;
            s.ctrl_reg = s.ctrl_reg & slsr_pkg::START_CLR_MASK;
            r.irq_request = 1'b1;
          end
        end else begin
          if ((s.send_status != slsr_pkg::SEND_IDLE) && (s.timer >= cfg.retx_cycles)) begin
            s.timer = '0;
            r.resend_valid = 1'b1;
            r.resend_seq = s.last_seq;
            r.resend_data = s.last_byte;
          end
          if (start) begin
            if (internal || (s.send_status == slsr_pkg::SEND_WAIT)) begin
              if (s.send_status == slsr_pkg::SEND_IDLE) begin
                s.last_seq = s.last_seq + 8'd1;
                s.last_byte = s.data_reg;
                r.tx_valid = 1'b1;
                r.tx_seq = s.last_seq;
                r.tx_data = s.last_byte;
                s.send_status = slsr_pkg::SEND_WAIT;
              end
              r.rx_taken = item.rx_valid;
              if (seq_ok) begin
                s.exp_seq = s.exp_seq + 8'd1;
                s.send_status = slsr_pkg::SEND_IDLE;
                s.timer = '0;
                s.data_reg = item.rx_data;
                s.ctrl_reg = s.ctrl_reg & slsr_pkg::START_CLR_MASK;
                r.irq_request = 1'b1;
              end else begin
                s.timer = timer_add(s.timer, item.elapsed_cycles);
              end
            end else begin
              r.rx_taken = item.rx_valid;
              if (seq_ok) begin
                s.timer = '0;
                s.last_seq = s.last_seq + 8'd1;
                s.exp_seq = s.exp_seq + 8'd1;
                s.last_byte = s.data_reg;
                r.tx_valid = 1'b1;
                r.tx_seq = s.last_seq;
                r.tx_data = s.last_byte;
                s.send_status = slsr_pkg::SEND_ANSWERED;
                s.data_reg = item.rx_data;
                s.ctrl_reg = s.ctrl_reg & slsr_pkg::START_CLR_MASK;
                r.irq_request = 1'b1;
              end else begin
                s.timer = timer_add(s.timer, item.elapsed_cycles);
              end
            end
          end
        end
      end
      default: begin
        s = st;
      end
    endcase
    r.data_reg = s.data_reg;
    r.control_reg = s.ctrl_reg;
    st_nxt = s;
    res = r;
  end

endmodule
